>>> rtl/epmd_pkg.sv
package epmd_pkg;

    localparam int RegCount = 8;
    localparam int AddrWidth = 5;

    // Reciprocal of 100 for the integral step: x/100 = (x * RecipHundred) >> RecipShift
    // for every error magnitude the controller can produce
    localparam logic [31:0] RecipHundred = 32'd10737419;
    localparam int RecipShift = 30;

    // Register indexes
    typedef enum logic [2:0] {
        REG_KP        = 3'd0,
        REG_KI        = 3'd1,
        REG_KD        = 3'd2,
        REG_ALPHA     = 3'd3,
        REG_RAMP      = 3'd4,
        REG_ILIMIT    = 3'd5,
        REG_PWM_TOP   = 3'd6,
        REG_INTERLOCK = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] kp;
        logic [15:0] ki;
        logic [15:0] kd;
        logic [8:0]  alpha;
        logic [14:0] ramp;
        logic [15:0] ilimit;
        logic [15:0] pwm_top;
        logic [15:0] interlock;
    } t_cfg;

    // Serial multiplier request: multiplicand, multiplier (both non-negative)
    typedef struct packed {
        logic        start;
        logic [47:0] mcand;
        logic [31:0] mplier;
    } t_mul_req;

    typedef struct packed {
        logic        done;
        logic [79:0] prod;
    } t_mul_rsp;

endpackage

>>> rtl/epmd_cfg.sv
module epmd_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [epmd_pkg::AddrWidth-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output epmd_pkg::t_cfg                   o_cfg
);
    import epmd_pkg::*;

    t_cfg r_cfg;
    t_reg_idx w_idx;

    assign w_idx  = t_reg_idx'(paddr[AddrWidth-1:2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Write registers on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp        <= 16'd1664;
            r_cfg.ki        <= 16'd768;
            r_cfg.kd        <= 16'd1024;
            r_cfg.alpha     <= 9'd77;
            r_cfg.ramp      <= 15'd512;
            r_cfg.ilimit    <= 16'd51200;
            r_cfg.pwm_top   <= 16'd3999;
            r_cfg.interlock <= 16'd10;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_KP:        r_cfg.kp        <= pwdata[15:0];
                REG_KI:        r_cfg.ki        <= pwdata[15:0];
                REG_KD:        r_cfg.kd        <= pwdata[15:0];
                REG_ALPHA:     r_cfg.alpha     <= pwdata[8:0];
                REG_RAMP:      r_cfg.ramp      <= pwdata[14:0];
                REG_ILIMIT:    r_cfg.ilimit    <= pwdata[15:0];
                REG_PWM_TOP:   r_cfg.pwm_top   <= pwdata[15:0];
                REG_INTERLOCK: r_cfg.interlock <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_KP:        prdata = {16'd0, r_cfg.kp};
            REG_KI:        prdata = {16'd0, r_cfg.ki};
            REG_KD:        prdata = {16'd0, r_cfg.kd};
            REG_ALPHA:     prdata = {23'd0, r_cfg.alpha};
            REG_RAMP:      prdata = {17'd0, r_cfg.ramp};
            REG_ILIMIT:    prdata = {16'd0, r_cfg.ilimit};
            REG_PWM_TOP:   prdata = {16'd0, r_cfg.pwm_top};
            REG_INTERLOCK: prdata = {16'd0, r_cfg.interlock};
            default:       prdata = '0;
        endcase
    end

endmodule

>>> rtl/epmd_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle.
module epmd_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  epmd_pkg::t_mul_req  i_req,
    output epmd_pkg::t_mul_rsp  o_rsp
);
    import epmd_pkg::*;

    logic [79:0] r_acc, n_acc;
    logic [79:0] r_mc, n_mc;
    logic [31:0] r_mp, n_mp;
    logic        r_busy, n_busy;
    logic        r_done, n_done;

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

    // Add the shifted multiplicand for each set bit, then advance
    always_comb begin
        n_acc  = r_acc;
        n_mc   = r_mc;
        n_mp   = r_mp;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_acc  = '0;
            n_mc   = {32'd0, i_req.mcand};
            n_mp   = i_req.mplier;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_mp[0])
                n_acc = r_acc + r_mc;
            n_mc = {r_mc[78:0], 1'b0};
            n_mp = {1'b0, r_mp[31:1]};
            if (r_mp[31:1] == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_acc <= n_acc;
        r_mc  <= n_mc;
        r_mp  <= n_mp;
    end

endmodule

>>> rtl/epmd_div.sv
// Restoring divider, one quotient bit per cycle (non-negative operands).
module epmd_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo
);
    logic [63:0] r_q, n_q;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [32:0] w_try;

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign w_try  = {r_rem[31:0], r_q[63]} - {1'b0, r_den};

    // Shift in one numerator bit, subtract where it fits
    always_comb begin
        n_q    = r_q;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_q    = i_num;
            n_rem  = '0;
            n_cnt  = 7'd64;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_try[32]) begin
                n_rem = w_try;
                n_q   = {r_q[62:0], 1'b1};
            end else begin
                n_rem = {r_rem[31:0], r_q[63]};
                n_q   = {r_q[62:0], 1'b0};
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        if (i_start)
            r_den <= i_den;
    end

endmodule

>>> rtl/encoder_pid_motor_drive.sv
// Each request is worked through by the serial multiplier (one multiplier bit per
// cycle, seven products, the longest 24 bits for the divide by 100) and the
// 64-step divider for the PWM scaling. A request is taken only in the idle
// state; the next request is taken while the result waits in the output register.
// Reset is synchronous, active low, and restores register defaults and clears the
// sequencer, filter, target, integral, last error, interlock levels and valid.
module encoder_pid_motor_drive (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [15:0]                     i_encoder_count,
    input  logic signed [15:0]              i_desired_speed,
    input  logic                            i_command_stale,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [15:0]                     o_forward_pwm,
    output logic [15:0]                     o_reverse_pwm,
    output logic signed [15:0]              o_measured_speed,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [epmd_pkg::AddrWidth-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import epmd_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_FILT1 = 11'b00000000010,
        S_FILT2 = 11'b00000000100,
        S_ERR   = 11'b00000001000,
        S_IDIV  = 11'b00000010000,
        S_KP    = 11'b00000100000,
        S_KI    = 11'b00001000000,
        S_KD    = 11'b00010000000,
        S_SCALE = 11'b00100000000,
        S_DIV   = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    t_cfg     w_cfg;
    t_mul_req w_mreq;
    t_mul_rsp w_mrsp;
    t_state   r_st;

    logic [15:0]        r_prev_cnt;
    logic signed [24:0] r_filt;
    logic signed [16:0] r_tgt;
    logic signed [17:0] r_isum;
    logic signed [24:0] r_perr;
    logic [15:0]        r_fwd_lvl, r_rev_lvl;
    logic signed [16:0] r_des;
    logic signed [24:0] r_e;
    logic signed [63:0] r_s;
    logic [8:0]         r_alpha;
    logic               r_ovalid;
    logic [15:0]        r_ofwd, r_orev;
    logic signed [15:0] r_oms;

    logic        w_div_start, w_div_done;
    logic [63:0] w_div_num, w_div_quo;

    epmd_cfg u_cfg (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_cfg(w_cfg)
    );

    epmd_mul u_mul (.i_clk, .i_rst_n, .i_req(w_mreq), .o_rsp(w_mrsp));

    epmd_div u_div (
        .i_clk, .i_rst_n, .i_start(w_div_start), .i_num(w_div_num),
        .i_den(32'd6553600), .o_done(w_div_done), .o_quo(w_div_quo)
    );

    // Signed product from the unsigned serial unit
    logic               r_neg;
    logic signed [63:0] w_sprod;
    assign w_sprod = r_neg ? -$signed(w_mrsp.prod[63:0]) : $signed(w_mrsp.prod[63:0]);

    function automatic logic [47:0] mag48(input logic signed [47:0] v);
        return v[47] ? 48'(-v) : 48'(v);
    endfunction

    // Combinational helpers
    logic signed [17:0] w_raw;
    logic signed [16:0] w_tgt_next;
    logic signed [24:0] w_m;
    logic signed [24:0] w_e;
    logic [24:0]        w_equo;
    logic signed [24:0] w_ediv;
    logic signed [18:0] w_isum;
    logic signed [17:0] w_isum_c;
    logic signed [33:0] w_fsum;
    logic signed [24:0] w_fnew;
    logic signed [17:0] w_up, w_dn;
    logic [15:0]        w_lvl, w_fwd, w_rev;
    logic               w_out_load;

    always_comb begin
        w_raw = 18'(i_encoder_count) - 18'(r_prev_cnt);
        if (w_raw > 18'sd32768)
            w_raw = w_raw - 18'sd65536;
        else if (w_raw < -18'sd32768)
            w_raw = w_raw + 18'sd65536;
    end

    // Filter sum: r_s plus the product gives alpha*raw*256 + (256-alpha)*filt; divide /256
    assign w_fsum = 34'(r_s) + 34'(w_sprod);
    assign w_fnew = 25'((w_fsum + (w_fsum < 0 ? 34'sd255 : 34'sd0)) >>> 8);
    assign w_m    = (r_filt + (r_filt < 0 ? 25'sd255 : 25'sd0)) >>> 8;

    always_comb begin
        w_up = 18'(r_tgt) + 18'(w_cfg.ramp);
        w_dn = 18'(r_tgt) - 18'(w_cfg.ramp);
        w_tgt_next = r_tgt;
        if (r_tgt < r_des)
            w_tgt_next = (w_up > 18'(r_des)) ? r_des : 17'(w_up);
        else if (r_tgt > r_des)
            w_tgt_next = (w_dn < 18'(r_des)) ? r_des : 17'(w_dn);
    end

    // Error, and the integral step with e/100 taken from the reciprocal product
    assign w_e    = 25'(r_tgt < 0 ? -r_tgt : r_tgt)
                  - ((w_m < 0 ? -w_m : w_m) <<< 8);
    assign w_equo = w_mrsp.prod[RecipShift +: 25];
    assign w_ediv = r_e[24] ? -$signed(w_equo) : $signed(w_equo);
    always_comb begin
        w_isum = 19'(r_isum) + 19'(w_ediv);
        if (w_isum > $signed({3'd0, w_cfg.ilimit}))
            w_isum_c = 18'($signed({2'd0, w_cfg.ilimit}));
        else if (w_isum < -$signed({3'd0, w_cfg.ilimit}))
            w_isum_c = -18'($signed({2'd0, w_cfg.ilimit}));
        else
            w_isum_c = 18'(w_isum);
    end

    assign w_lvl = (w_div_quo > 64'(w_cfg.pwm_top)) ? w_cfg.pwm_top : w_div_quo[15:0];
    always_comb begin
        w_fwd = (r_tgt > 0) ? w_lvl : 16'd0;
        w_rev = (r_tgt < 0) ? w_lvl : 16'd0;
        if (r_s <= 0) begin
            w_fwd = '0;
            w_rev = '0;
        end
        if (r_fwd_lvl > w_cfg.interlock && w_rev != 0)
            w_rev = '0;
        if (r_rev_lvl > w_cfg.interlock && w_fwd != 0)
            w_fwd = '0;
    end

    assign w_div_start = (r_st == S_SCALE) && w_mrsp.done;
    assign w_div_num   = w_mrsp.prod[63:0];
    assign w_out_load  = (r_st == S_OUT) && (!r_ovalid || i_ready);
    assign o_ready = (r_st == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_forward_pwm = r_ofwd;
    assign o_reverse_pwm = r_orev;
    assign o_measured_speed = r_oms;

    // Multiplier launches
    always_comb begin
        w_mreq = '0;
        unique case (r_st)
            S_IDLE:  begin
                w_mreq.start  = i_valid && o_ready;
                w_mreq.mcand  = mag48(48'(w_raw) <<< 8);
                w_mreq.mplier = 32'(w_cfg.alpha > 9'd256 ? 9'd256 : w_cfg.alpha);
            end
            S_FILT1: begin
                w_mreq.start  = w_mrsp.done;
                w_mreq.mcand  = mag48(48'(r_filt));
                w_mreq.mplier = 32'(10'd256 - 10'(r_alpha));
            end
            S_ERR:   begin
                w_mreq.start  = r_tgt != 0;
                w_mreq.mcand  = mag48(48'(w_e));
                w_mreq.mplier = RecipHundred;
            end
            S_IDIV:  begin
                w_mreq.start  = w_mrsp.done;
                w_mreq.mcand  = mag48(48'(r_e));
                w_mreq.mplier = 32'(w_cfg.kp);
            end
            S_KP:    begin
                w_mreq.start  = w_mrsp.done;
                w_mreq.mcand  = mag48(48'(r_isum));
                w_mreq.mplier = 32'(w_cfg.ki);
            end
            S_KI:    begin
                w_mreq.start  = w_mrsp.done;
                w_mreq.mcand  = mag48(48'(r_e) - 48'(r_perr));
                w_mreq.mplier = 32'(w_cfg.kd);
            end
            S_KD:    begin
                w_mreq.start  = w_mrsp.done && (r_s + w_sprod > 0);
                w_mreq.mcand  = 48'(r_s + w_sprod);
                w_mreq.mplier = 32'(w_cfg.pwm_top);
            end
            default: w_mreq = '0;
        endcase
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_prev_cnt <= '0; r_filt <= '0; r_tgt <= '0; r_isum <= '0;
            r_perr <= '0; r_fwd_lvl <= '0; r_rev_lvl <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // Hold the result until taken; load the next one once the slot frees
            if (w_out_load)
                r_ovalid <= 1'b1;
            else if (i_ready)
                r_ovalid <= 1'b0;
            unique case (r_st)
                S_IDLE: if (i_valid && o_ready) begin
                    r_prev_cnt <= i_encoder_count;
                    r_des <= i_command_stale ? 17'sd0 : 17'(i_desired_speed);
                    r_alpha <= w_cfg.alpha > 9'd256 ? 9'd256 : w_cfg.alpha;
                    r_neg <= w_raw[17];
                    r_st <= S_FILT1;
                end
                S_FILT1: if (w_mrsp.done) begin
                    r_s <= w_sprod;
                    r_neg <= r_filt[24];
                    r_st <= S_FILT2;
                end
                S_FILT2: if (w_mrsp.done) begin
                    r_filt <= w_fnew;
                    r_tgt <= w_tgt_next;
                    r_st <= S_ERR;
                end
                S_ERR: begin
                    r_e <= w_e;
                    r_neg <= w_e[24];
                    r_s <= '0;
                    if (r_tgt == 0) begin
                        r_isum <= '0; r_perr <= '0;
                        r_st <= S_OUT;
                    end else begin
                        r_st <= S_IDIV;
                    end
                end
                S_IDIV: if (w_mrsp.done) begin
                    r_isum <= w_isum_c;
                    r_st <= S_KP;
                end
                S_KP: if (w_mrsp.done) begin
                    r_s <= r_s + w_sprod;
                    r_neg <= r_isum[17];
                    r_st <= S_KI;
                end
                S_KI: if (w_mrsp.done) begin
                    r_s <= r_s + w_sprod;
                    r_neg <= (r_e - r_perr) < 0;
                    r_st <= S_KD;
                end
                S_KD: if (w_mrsp.done) begin
                    r_s <= r_s + w_sprod;
                    r_perr <= r_e;
                    r_neg <= 1'b0;
                    r_st <= (r_s + w_sprod > 0) ? S_SCALE : S_OUT;
                end
                S_SCALE: if (w_mrsp.done) r_st <= S_DIV;
                S_DIV:   if (w_div_done) r_st <= S_OUT;
                S_OUT: if (w_out_load) begin
                    r_fwd_lvl <= w_fwd;
                    r_rev_lvl <= w_rev;
                    r_ofwd <= w_fwd;
                    r_orev <= w_rev;
                    r_oms <= (w_m > 25'sd32767) ? 16'sd32767 : 16'(w_m);
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/epmd_checker.sv
module epmd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_forward_pwm,
    input logic [15:0] o_reverse_pwm,
    input logic [15:0] o_measured_speed
);
    // Only one channel driven at a time
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_forward_pwm == 16'd0 || o_reverse_pwm == 16'd0))
        else $error("both channels driven");

    // Result held until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_forward_pwm)
            && $stable(o_reverse_pwm) && $stable(o_measured_speed))
        else $error("result dropped or changed");

    // No result straight after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind encoder_pid_motor_drive epmd_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_ready,
    .o_forward_pwm, .o_reverse_pwm, .o_measured_speed
);

>>> tb/encoder_pid_motor_drive_tb.sv
`timescale 1ns / 100ps

module encoder_pid_motor_drive_tb;
    import epmd_pkg::*;

    localparam int IdleLimit = 20000;
    localparam int LongHoldCycles = 3000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [15:0] i_encoder_count = '0;
    logic signed [15:0] i_desired_speed = '0;
    logic i_command_stale = 1'b0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [15:0] o_forward_pwm;
    logic [15:0] o_reverse_pwm;
    logic signed [15:0] o_measured_speed;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [AddrWidth-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    typedef struct {
        logic [15:0]        fwd;
        logic [15:0]        rev;
        logic signed [15:0] speed;
    } t_drive;

    // Directed stimulus row; check_fixed marks rows whose result is typed in
    typedef struct {
        logic [15:0]        count;
        logic signed [15:0] desired;
        logic               stale;
        logic               check_fixed;
        t_drive             fixed;
    } t_row;

    encoder_pid_motor_drive dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Controller model state and register copy
    longint kp, ki, kd, alpha_reg, ramp, ilimit, pwm_top, interlock;
    longint last_count, filt, target, integ, last_err, fwd_lvl, rev_lvl;

    t_drive expected_drive[$];
    int     errors = 0;
    int     requests_sent = 0;
    int     drives_seen = 0;
    int     idle_cycles = 0;
    bit     long_hold = 1'b0;

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    task automatic model_reset();
        kp = 1664; ki = 768; kd = 1024; alpha_reg = 77; ramp = 512;
        ilimit = 51200; pwm_top = 3999; interlock = 10;
        last_count = 0; filt = 0; target = 0; integ = 0; last_err = 0;
        fwd_lvl = 0; rev_lvl = 0;
    endtask

    // Compute the drive outputs for one control tick and advance the state
    function automatic t_drive predict_drive(logic [15:0] count,
                                             logic signed [15:0] desired_in,
                                             logic stale);
        longint desired, raw, a, m, e, s, q, lvl, fwd, rev;
        t_drive d;
        desired = stale ? 0 : longint'(desired_in);
        raw = longint'(count) - last_count;
        if (raw > 32768) raw -= 65536;
        else if (raw < -32768) raw += 65536;
        last_count = count;
        a = alpha_reg > 256 ? 256 : alpha_reg;
        filt = (a * raw * 256 + (256 - a) * filt) / 256;
        m = filt / 256;
        if (target < desired) begin
            target += ramp;
            if (target > desired) target = desired;
        end else if (target > desired) begin
            target -= ramp;
            if (target < desired) target = desired;
        end
        lvl = 0;
        if (target == 0) begin
            integ = 0;
            last_err = 0;
        end else begin
            e = mag(target) - mag(m) * 256;
            integ += e / 100;
            if (integ > ilimit) integ = ilimit;
            else if (integ < -ilimit) integ = -ilimit;
            s = kp * e + ki * integ + kd * (e - last_err);
            if (s > 0) begin
                q = (s * pwm_top) / 6553600;
                lvl = q > pwm_top ? pwm_top : q;
            end
            last_err = e;
        end
        fwd = target > 0 ? lvl : 0;
        rev = target < 0 ? lvl : 0;
        if (fwd_lvl > interlock && rev > 0) rev = 0;
        if (rev_lvl > interlock && fwd > 0) fwd = 0;
        fwd_lvl = fwd;
        rev_lvl = rev;
        d.fwd = fwd[15:0];
        d.rev = rev[15:0];
        d.speed = m > 32767 ? 16'sd32767 : (m < -32768 ? -16'sd32768 : m[15:0]);
        return d;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on drive %0d: %s got %0d want %0d",
                 drives_seen, what, got, want);
        errors++;
    endtask

    // APB register write, setup then access
    task automatic write_reg(t_reg_idx idx, logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= AddrWidth'(4 * int'(idx)); pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_KP:        kp = value[15:0];
            REG_KI:        ki = value[15:0];
            REG_KD:        kd = value[15:0];
            REG_ALPHA:     alpha_reg = value[8:0];
            REG_RAMP:      ramp = value[14:0];
            REG_ILIMIT:    ilimit = value[15:0];
            REG_PWM_TOP:   pwm_top = value[15:0];
            REG_INTERLOCK: interlock = value[15:0];
            default: ;
        endcase
    endtask

    // Offer one request, hold until accepted, then predict
    task automatic send_request(logic [15:0] count, logic signed [15:0] desired,
                                logic stale, bit use_fixed, t_drive fixed);
        t_drive d;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_encoder_count <= count;
        i_desired_speed <= desired;
        i_command_stale <= stale;
        do @(posedge i_clk); while (!o_ready);
        d = predict_drive(count, desired, stale);
        // Typed-in rows are checked against their own result
        if (use_fixed)
            expected_drive.push_back(fixed);
        else
            expected_drive.push_back(d);
        requests_sent++;
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic send_burst_gap();
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 30)) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (expected_drive.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
    endtask

    // Receiver stall pattern, with one long hold-off counted here
    initial begin
        int phase;
        int hold_left;
        phase = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            phase++;
            if (long_hold) begin
                hold_left = LongHoldCycles;
                long_hold = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end
            else if (phase % 64 < 20) i_ready <= 1'b1;
            else i_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Compare accepted drives with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            t_drive w;
            drives_seen++;
            if (expected_drive.size() == 0) begin
                report_mismatch("unexpected drive", 0, 0);
            end else begin
                w = expected_drive.pop_front();
                if (o_forward_pwm !== w.fwd)
                    report_mismatch("forward_pwm", o_forward_pwm, w.fwd);
                if (o_reverse_pwm !== w.rev)
                    report_mismatch("reverse_pwm", o_reverse_pwm, w.rev);
                if (o_measured_speed !== w.speed)
                    report_mismatch("measured_speed", o_measured_speed, w.speed);
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IdleLimit) begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        t_row r;
        t_drive zero_drive;
        logic [15:0] cnt;
        int phase_no;
        zero_drive = '{fwd: 16'd0, rev: 16'd0, speed: 16'sd0};
        model_reset();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero, extremes, stale, rollover both ways, reversal
        rows = '{
            '{16'd0, 16'sd0, 1'b0, 1'b1, zero_drive},
            '{16'd0, 16'sd25600, 1'b1, 1'b1, zero_drive},
            '{16'd0, 16'sd25600, 1'b0, 1'b0, zero_drive},
            '{16'd100, 16'sd25600, 1'b0, 1'b0, zero_drive},
            '{16'd65500, 16'sd25600, 1'b0, 1'b0, zero_drive},
            '{16'd40, 16'sd25600, 1'b0, 1'b0, zero_drive},
            '{16'd32808, 16'sd25600, 1'b0, 1'b0, zero_drive},
            '{16'd40, -16'sd25600, 1'b0, 1'b0, zero_drive},
            '{16'd65535, -16'sd25600, 1'b0, 1'b0, zero_drive},
            '{16'd65000, -16'sd25600, 1'b0, 1'b0, zero_drive},
            '{16'd64000, -16'sd25600, 1'b0, 1'b0, zero_drive},
            '{16'd64000, -16'sd32768, 1'b0, 1'b0, zero_drive},
            '{16'd64000, 16'sd32767, 1'b0, 1'b0, zero_drive},
            '{16'd64000, 16'sd300, 1'b1, 1'b0, zero_drive},
            '{16'd64100, 16'sd1, 1'b0, 1'b0, zero_drive},
            '{16'd64100, 16'sd0, 1'b0, 1'b0, zero_drive}
        };
        foreach (rows[k]) begin
            r = rows[k];
            send_request(r.count, r.desired, r.stale, r.check_fixed, r.fixed);
        end
        wait_drained();

        // Random phases over several register settings, extremes included
        cnt = 16'd0;
        for (phase_no = 0; phase_no < 6; phase_no++) begin
            case (phase_no)
                0: ;
                1: begin
                    write_reg(REG_KP, 32'hFFFF); write_reg(REG_KI, 32'hFFFF);
                    write_reg(REG_KD, 32'hFFFF); write_reg(REG_ALPHA, 32'd256);
                    write_reg(REG_RAMP, 32'd25600); write_reg(REG_ILIMIT, 32'hFFFF);
                    write_reg(REG_PWM_TOP, 32'hFFFF); write_reg(REG_INTERLOCK, 32'hFFFF);
                end
                2: begin
                    write_reg(REG_KP, 32'd0); write_reg(REG_KI, 32'd0);
                    write_reg(REG_KD, 32'd0); write_reg(REG_ALPHA, 32'd0);
                    write_reg(REG_RAMP, 32'd1); write_reg(REG_ILIMIT, 32'd0);
                    write_reg(REG_PWM_TOP, 32'd1); write_reg(REG_INTERLOCK, 32'd0);
                end
                3: begin
                    write_reg(REG_KP, 32'd1664); write_reg(REG_KI, 32'd768);
                    write_reg(REG_KD, 32'd1024); write_reg(REG_ALPHA, 32'd511);
                    write_reg(REG_RAMP, 32'd0); write_reg(REG_ILIMIT, 32'd51200);
                    write_reg(REG_PWM_TOP, 32'd0); write_reg(REG_INTERLOCK, 32'd10);
                end
                default: begin
                    write_reg(REG_KP, $urandom_range(0, 65535));
                    write_reg(REG_KI, $urandom_range(0, 65535));
                    write_reg(REG_KD, $urandom_range(0, 65535));
                    write_reg(REG_ALPHA, $urandom_range(0, 511));
                    write_reg(REG_RAMP, $urandom_range(1, 32767));
                    write_reg(REG_ILIMIT, $urandom_range(0, 65535));
                    write_reg(REG_PWM_TOP, $urandom_range(1, 65535));
                    write_reg(REG_INTERLOCK, $urandom_range(0, 65535));
                end
            endcase
            for (int n = 0; n < 200; n++) begin
                logic signed [15:0] want;
                // Mostly plausible motion, sometimes wild counts and any command
                if ($urandom_range(0, 9) == 0) cnt = $urandom();
                else cnt = cnt + 16'($signed($urandom_range(0, 600)) - 300);
                if ($urandom_range(0, 9) == 0) want = $urandom();
                else want = $signed($urandom_range(0, 51200)) - 25600;
                if (phase_no == 4 && n == 20) long_hold = 1'b1;
                send_request(cnt, want, $urandom_range(0, 15) == 0, 1'b0, zero_drive);
                send_burst_gap();
            end
            wait_drained();
        end

        $display("%0d ticks sent, %0d drives checked, six register settings",
                 requests_sent, drives_seen);
        if (errors == 0 && expected_drive.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d drives still pending",
                     errors, expected_drive.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> encoder_pid_motor_drive.f
rtl/epmd_pkg.sv
rtl/epmd_cfg.sv
rtl/epmd_mul.sv
rtl/epmd_div.sv
rtl/encoder_pid_motor_drive.sv
rtl/epmd_checker.sv
tb/encoder_pid_motor_drive_tb.sv
